/* rtl/wheel_period_speed_meter_top_macros.svh */
// Assertion macros for the wheel period speed meter.
// Used by modules that carry concurrent checks; empty under synthesis.
`ifndef WHEEL_PERIOD_SPEED_METER_TOP_MACROS_SVH
`define WHEEL_PERIOD_SPEED_METER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define WPSM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wpsm check failed");
`define WPSM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wpsm check failed");
`else
`define WPSM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define WPSM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/wpsm_pkg.sv */
// Package of the wheel period speed meter: widths, reset values,
// capture record, back-end state type. No dependencies.
package wpsm_pkg;

	localparam int TICK_W   = 16;
	localparam int DZ_W     = 10;
	localparam int NUM_W    = 29;
	localparam int PERIOD_W = 30;
	localparam int SPEED_W  = 29;
	localparam int WRAP_W   = 14;

	localparam logic [DZ_W-1:0]   DEAD_ZONE_RST = 10'd976;
	localparam logic [NUM_W-1:0]  SPEED_NUM_RST = 29'd508680000;
	localparam logic [WRAP_W-1:0] WRAP_US       = 14'd13107;
	localparam logic [SPEED_W-1:0] SPEED_MAX    = 29'h1FFF_FFFF;

	localparam int DIV_STEPS  = SPEED_W;
	localparam int STEP_W     = $clog2(DIV_STEPS);
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = NUM_W;
	localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_NUM = 1'b1;

	typedef struct packed {
		logic [TICK_W-1:0] ovf;
		logic [TICK_W-1:0] ticks;
	} capture_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_CORR,
		BK_SUM,
		BK_DIV,
		BK_DONE
	} back_state_t;

endpackage

/* rtl/wpsm_tick_if.sv */
// Tick channel: one timer tick per beat with the sensor edge flag.
// Valid/ready handshake; no dependencies.
interface wpsm_tick_if;
	logic valid;
	logic ready;
	logic edge_req;

	modport source (output valid, output edge_req, input ready);
	modport sink (input valid, input edge_req, output ready);
endinterface

/* rtl/wpsm_result_if.sv */
// Result channel: period in us and speed in 0.01 km/h per beat.
// Valid/ready handshake; no dependencies.
interface wpsm_result_if;
	logic        valid;
	logic        ready;
	logic [29:0] period_us;
	logic [28:0] speed_centi_kmh;

	modport source (output valid, output period_us, output speed_centi_kmh, input ready);
	modport sink (input valid, input period_us, input speed_centi_kmh, output ready);
endinterface

/* rtl/wpsm_front.sv */
// Front end: tick and overflow counters, blanking window, edge pairing.
// Pushes the counters of every other unblanked edge. Uses wpsm_pkg, wpsm_tick_if.
module wpsm_front import wpsm_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	wpsm_tick_if.sink       tick,
	input  logic [DZ_W-1:0] dead_zone_ticks,
	input  logic            fifo_full,
	output logic            push,
	output capture_t        push_data
);

	logic              accept;
	logic              take_edge;
	logic [TICK_W-1:0] tick_q;
	logic [TICK_W-1:0] ovf_q;
	logic              counting_q;
	logic [DZ_W-1:0]   blank_q;
	logic              odd_q;

	assign tick.ready = !fifo_full;
	assign accept     = tick.valid && tick.ready;
	assign take_edge  = accept && tick.edge_req && (blank_q == '0);
	assign push       = take_edge && odd_q;
	assign push_data  = '{ovf: ovf_q, ticks: tick_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q     <= '0;
			ovf_q      <= '0;
			counting_q <= 1'b0;
			blank_q    <= '0;
			odd_q      <= 1'b0;
		end else if (take_edge) begin
			tick_q     <= '0;
			ovf_q      <= '0;
			counting_q <= 1'b1;
			blank_q    <= dead_zone_ticks;
			odd_q      <= !odd_q;
		end else if (accept) begin
			if (blank_q != '0) begin
				blank_q <= blank_q - DZ_W'(1);
			end
			tick_q <= tick_q + TICK_W'(1);
			// overflow saturates
			if ((tick_q == '1) && counting_q && (ovf_q != '1)) begin
				ovf_q <= ovf_q + TICK_W'(1);
			end
		end
	end

endmodule

/* rtl/wpsm_fifo.sv */
// Two-entry capture queue between front and back ends.
// Uses wpsm_pkg and the assertion macros.
`include "wheel_period_speed_meter_top_macros.svh"
module wpsm_fifo import wpsm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  capture_t push_data,
	input  logic     pop,
	output logic     full,
	output logic     empty,
	output capture_t rd_data
);

	capture_t              mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	assign full    = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + FIFO_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - FIFO_CNT_W'(1);
			end
		end
	end

	`WPSM_ASSERT_IMP(a_no_push_full, clk, arst_n, push, !full)
	`WPSM_ASSERT_IMP(a_no_pop_empty, clk, arst_n, pop, !empty)
	`WPSM_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= FIFO_CNT_W'(FIFO_DEPTH))
	`WPSM_ASSERT_NXT(a_push_fills, clk, arst_n, push && !pop, !empty)

endmodule

/* rtl/wpsm_back.sv */
// Back end: period from captured counters, restoring divider for speed,
// output register. Uses wpsm_pkg, wpsm_result_if.
module wpsm_back import wpsm_pkg::*; #(
	parameter int TICK_DIVISOR = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             empty,
	input  capture_t         rd_data,
	input  logic [NUM_W-1:0] speed_numerator,
	output logic             pop,
	wpsm_result_if.source    result
);

	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int RECIP       = (1 << RECIP_SHIFT) / TICK_DIVISOR;
	localparam int DIVR_W      = $clog2(TICK_DIVISOR + 1);
	localparam int CHK_W       = TICK_W + DIVR_W;
	localparam int RPROD_W     = TICK_W + RECIP_W;

	back_state_t state_q, state_d;
	logic        load;

	logic [TICK_W-1:0]         ovf_q;
	logic [TICK_W-1:0]         ticks_q;
	logic [PERIOD_W-1:0]       ovf_prod_q;
	logic [TICK_W-1:0]         quo0_q;
	logic [TICK_W-1:0]         quo_q;
	logic [PERIOD_W-1:0]       period_q;
	logic [PERIOD_W-1:0]       rem_q;
	logic [NUM_W-1:0]          num_q;
	logic [SPEED_W-1:0]        quot_q;
	logic [STEP_W-1:0]         step_q;
	logic                      out_valid_q;
	logic [PERIOD_W-1:0]       out_period_q;
	logic [SPEED_W-1:0]        out_speed_q;

	logic [RPROD_W-1:0]        recip_prod;
	logic [CHK_W-1:0]          back_prod;
	logic [CHK_W-1:0]          tick_rem;
	logic                      quo_fix;
	logic [PERIOD_W:0]         rem_shift;
	logic [PERIOD_W:0]         rem_diff;
	logic                      rem_ge;

	assign recip_prod = RPROD_W'(ticks_q) * RPROD_W'(RECIP);
	assign back_prod  = CHK_W'(quo0_q) * CHK_W'(TICK_DIVISOR);
	assign tick_rem   = CHK_W'(ticks_q) - back_prod;
	assign quo_fix    = (tick_rem >= CHK_W'(TICK_DIVISOR));

	assign rem_shift = {rem_q, num_q[NUM_W-1]};
	assign rem_diff  = rem_shift - {1'b0, period_q};
	assign rem_ge    = (rem_shift >= {1'b0, period_q});

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: if (!empty) state_d = BK_MUL;
			BK_MUL:  state_d = BK_CORR;
			BK_CORR: state_d = BK_SUM;
			BK_SUM:  state_d = BK_DIV;
			BK_DIV:  if (step_q == STEP_W'(DIV_STEPS - 1)) state_d = BK_DONE;
			BK_DONE: if (load) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop  = (state_q == BK_IDLE) && !empty;
		load = (state_q == BK_DONE) && (!out_valid_q || result.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				ovf_q   <= rd_data.ovf;
				ticks_q <= rd_data.ticks;
			end
			BK_MUL: begin
				ovf_prod_q <= PERIOD_W'(ovf_q) * PERIOD_W'(WRAP_US);
				quo0_q     <= recip_prod[RECIP_SHIFT +: TICK_W];
			end
			BK_CORR: begin
				quo_q <= quo_fix ? quo0_q + TICK_W'(1) : quo0_q;
			end
			BK_SUM: begin
				period_q <= ovf_prod_q + PERIOD_W'(quo_q);
				rem_q    <= '0;
				num_q    <= speed_numerator;
				quot_q   <= '0;
				step_q   <= '0;
			end
			BK_DIV: begin
				rem_q  <= rem_ge ? rem_diff[PERIOD_W-1:0] : rem_shift[PERIOD_W-1:0];
				num_q  <= {num_q[NUM_W-2:0], 1'b0};
				quot_q <= {quot_q[SPEED_W-2:0], rem_ge};
				step_q <= step_q + STEP_W'(1);
			end
			default: begin
			end
		endcase
		if (load) begin
			out_period_q <= period_q;
			out_speed_q  <= (period_q == '0) ? SPEED_MAX : quot_q;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.period_us       = out_period_q;
	assign result.speed_centi_kmh = out_speed_q;

endmodule

/* rtl/wheel_period_speed_meter_top.sv */
// Wheel period speed meter: measures the sensor period between edge pairs
// and derives the wheel speed.
//
// Channels: tick (sink) takes one 200 ns timer tick per beat with edge_req;
// result (source) gives period_us and speed_centi_kmh on every other
// unblanked sensor edge. cfg_we/cfg_index/cfg_wdata write dead_zone_ticks
// (index 0) and speed_numerator (index 1); other data bits are dropped.
// Throughput: one tick per cycle while tick.ready is high. Between the
// tick carrying its edge and its result lie the queue hand-off, multiply,
// quotient correction and period sum, the one-bit-per-cycle restoring
// divider, then the output register. The back end takes a new capture
// only once its last result is in the output register; a two-entry queue
// holds captures meanwhile, and tick.ready drops only while it is full.
// Reset clears the front-end counters, empties the queue, clears result.valid
// and loads the register reset values. On a receiver stall the result
// is held in the output register; ticks count until the queue fills.
// Depends on wpsm_pkg, the interfaces, wpsm_front, wpsm_fifo, wpsm_back.
module wheel_period_speed_meter_top import wpsm_pkg::*; #(
	parameter int TICK_DIVISOR = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	wpsm_tick_if.sink            tick,
	wpsm_result_if.source        result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	logic [DZ_W-1:0]  dead_zone_q;
	logic [NUM_W-1:0] speed_num_q;
	logic             push;
	logic             pop;
	logic             full;
	logic             empty;
	capture_t         push_data;
	capture_t         rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_zone_q <= DEAD_ZONE_RST;
			speed_num_q <= SPEED_NUM_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEAD_ZONE: dead_zone_q <= cfg_wdata[DZ_W-1:0];
				CFG_SPEED_NUM: speed_num_q <= cfg_wdata[NUM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	wpsm_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.tick            (tick),
		.dead_zone_ticks (dead_zone_q),
		.fifo_full       (full),
		.push            (push),
		.push_data       (push_data)
	);

	wpsm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.full      (full),
		.empty     (empty),
		.rd_data   (rd_data)
	);

	wpsm_back #(
		.TICK_DIVISOR (TICK_DIVISOR)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.empty           (empty),
		.rd_data         (rd_data),
		.speed_numerator (speed_num_q),
		.pop             (pop),
		.result          (result)
	);

endmodule
